// ===== design/bcfr_pkg.sv =====
// shared types and constants for the bus and core frequency block
`timescale 1ns / 1ps
package bcfr_pkg;
    localparam int unsigned TSC_W   = 38;
    localparam int unsigned CORE_W  = 43;
    localparam int unsigned DFLT_W  = 30;
    localparam int unsigned DIV_W   = 39;
    localparam int unsigned DEN_W   = 8;
    localparam int unsigned CNT_W   = 6;
    localparam logic [31:0] VENDOR_FIRST  = 32'h756E6547;
    localparam logic [31:0] VENDOR_SECOND = 32'h68747541;
    localparam logic [DFLT_W-1:0] DEFAULT_BUS_RST = 30'd100000000;

    typedef enum logic [2:0] {
        PATH_PLAT = 3'd0,
        PATH_PERF = 3'd1,
        PATH_OLD2 = 3'd2,
        PATH_NEW2 = 3'd3,
        PATH_NONE = 3'd4
    } t_path;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    // classified job handed from front to back
    typedef struct packed {
        t_path              path;
        logic [DIV_W-1:0]   num;
        logic [DEN_W-1:0]   den;
        logic               den_zero;
        logic [5:0]         cmul;
        logic               half;
        logic [TSC_W-1:0]   tsc;
    } t_job;
endpackage

// ===== design/bus_and_core_freq_from_ratio.sv =====
// top level: bus and core frequency from processor ratio words
// Each beat passes through the back end in order: a load in the idle state, the
// bit-serial restoring divider (one quotient bit a cycle), then the core multiply
// and fallback choice into the output register. A two-entry queue lets the front
// accept new beats while the back is busy or its result waits on stall.
`timescale 1ns / 1ps
module bus_and_core_freq_from_ratio (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bcfr_pkg::DFLT_W-1:0] i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [31:0]                 i_vendor_word,
    input  logic [31:0]                 i_signature,
    input  logic [bcfr_pkg::TSC_W-1:0]  i_tsc_hz,
    input  logic [63:0]                 i_ratio_status,
    input  logic [63:0]                 i_flex_status,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bcfr_pkg::TSC_W-1:0]  o_bus_hz,
    output logic [bcfr_pkg::CORE_W-1:0] o_core_hz,
    output logic [2:0]                  o_ratio_path,
    output logic                        o_default_used
);
    import bcfr_pkg::*;

    logic [DFLT_W-1:0] r_default_bus_hz;
    t_job front_job, q_job;
    logic q_full, q_empty, q_pop, push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_bus_hz <= DEFAULT_BUS_RST;
        end else if (i_cfg_we) begin
            r_default_bus_hz <= i_cfg_wdata;
        end
    end

    assign o_stall = q_full;
    assign push    = i_valid && !q_full;

    bcfr_front u_front (
        .i_vendor_word (i_vendor_word),
        .i_signature   (i_signature),
        .i_tsc_hz      (i_tsc_hz),
        .i_ratio_status(i_ratio_status),
        .i_flex_status (i_flex_status),
        .o_job         (front_job)
    );

    bcfr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_job  (q_job)
    );

    bcfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_default_bus_hz(r_default_bus_hz),
        .i_job_valid     (!q_empty),
        .i_job           (q_job),
        .o_job_pop       (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_bus_hz        (o_bus_hz),
        .o_core_hz       (o_core_hz),
        .o_ratio_path    (o_ratio_path),
        .o_default_used  (o_default_used)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("pop from empty queue");
    a_path_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_ratio_path <= 3'd4) else $error("bad ratio path");
    a_dflt_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_default_used) |-> o_bus_hz != '0) else $error("zero bus not defaulted");
endmodule

// ===== design/bcfr_front.sv =====
// front end: decode vendor and signature, pick the ratio rule, form the division
`timescale 1ns / 1ps
module bcfr_front (
    input  logic [31:0]               i_vendor_word,
    input  logic [31:0]               i_signature,
    input  logic [bcfr_pkg::TSC_W-1:0] i_tsc_hz,
    input  logic [63:0]               i_ratio_status,
    input  logic [63:0]               i_flex_status,
    output bcfr_pkg::t_job            o_job
);
    import bcfr_pkg::*;

    logic [7:0] model;
    logic [3:0] family;
    logic [7:0] extfam;
    logic [7:0] cc8;
    logic [4:0] cc5;
    logic [4:0] mc5;
    logic [6:0] amd_r;
    logic       first_v;

    always_comb begin
        model   = {i_signature[19:16], i_signature[7:4]};
        family  = i_signature[11:8];
        extfam  = i_signature[27:20];
        first_v = (i_vendor_word == VENDOR_FIRST);
        cc8     = i_ratio_status[15:8];
        if (i_flex_status[16] && (cc8 > i_flex_status[15:8])) begin
            cc8 = i_flex_status[15:8];
        end
        cc5 = i_ratio_status[12:8];
        mc5 = ((family == 4'h6 && model >= 8'h0e) || family == 4'hf)
            ? i_ratio_status[44:40] : cc5;
        if (extfam == 8'd0) begin
            amd_r = {2'b00, i_ratio_status[5:1]} + 7'd4;
        end else begin
            amd_r = {1'b0, i_ratio_status[5:0]} + ((extfam == 8'd1) ? 7'h10 : 7'h08);
        end

        o_job          = '0;
        o_job.tsc      = i_tsc_hz;
        o_job.path     = PATH_NONE;
        o_job.num      = {1'b0, i_tsc_hz};
        o_job.den_zero = 1'b1;
        if (first_v && ((family == 4'h6 && model >= 8'h0c) ||
                        (family == 4'hf && model >= 8'h03))) begin
            if (family == 4'h6 && (model == 8'h1a || model == 8'h1e)) begin
                o_job.path     = PATH_PLAT;
                o_job.den      = cc8;
                o_job.den_zero = (cc8 == 8'd0);
            end else begin
                o_job.path     = PATH_PERF;
                o_job.den_zero = (mc5 == 5'd0);
                o_job.cmul     = i_ratio_status[14] ? {cc5, 1'b1} : {1'b0, cc5};
                o_job.half     = i_ratio_status[14];
                if (i_ratio_status[46]) begin
                    o_job.num = {i_tsc_hz, 1'b0};
                    o_job.den = {2'b00, mc5, 1'b1};
                end else begin
                    o_job.den = {3'b000, mc5};
                end
            end
        end else if (i_vendor_word == VENDOR_SECOND && family == 4'hf) begin
            o_job.path     = (extfam == 8'd0) ? PATH_OLD2 : PATH_NEW2;
            o_job.den      = {1'b0, amd_r};
            o_job.den_zero = 1'b0;
        end
    end
endmodule

// ===== design/bcfr_queue.sv =====
// two-entry job queue between front and back
`timescale 1ns / 1ps
module bcfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bcfr_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bcfr_pkg::t_job o_job
);
    import bcfr_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== design/bcfr_back.sv =====
// back end: serial divider, core multiply and fallback, with output register
`timescale 1ns / 1ps
module bcfr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bcfr_pkg::DFLT_W-1:0] i_default_bus_hz,
    input  logic                        i_job_valid,
    input  bcfr_pkg::t_job              i_job,
    output logic                        o_job_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bcfr_pkg::TSC_W-1:0]  o_bus_hz,
    output logic [bcfr_pkg::CORE_W-1:0] o_core_hz,
    output logic [2:0]                  o_ratio_path,
    output logic                        o_default_used
);
    import bcfr_pkg::*;

    t_state             r_state, n_state;
    t_job               r_job;
    logic [DIV_W-1:0]   r_quo;
    logic [DEN_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic [TSC_W+5:0]   prod;
    logic [TSC_W-1:0]   bus;

    // one quotient bit a cycle, restoring
    assign trial = {r_rem, r_job.num[DIV_W-1]};
    assign diff  = trial - {1'b0, r_job.den};
    assign bus   = r_quo[TSC_W-1:0];
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_job_valid) n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CNT_W'(DIV_W - 1)) n_state = ST_MUL;
            ST_MUL:  if (!o_valid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MUL && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job <= i_job;
                r_rem <= '0;
                r_quo <= '0;
            end
            ST_DIV: begin
                if (!diff[DEN_W]) begin
                    r_rem <= diff[DEN_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[DEN_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_job.num <= {r_job.num[DIV_W-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    assign prod = bus * r_job.cmul;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL && (!o_valid || !i_stall)) begin
            o_ratio_path <= r_job.path;
            if (r_job.den_zero || bus == '0) begin
                o_bus_hz       <= {8'd0, i_default_bus_hz};
                o_core_hz      <= {5'd0, r_job.tsc};
                o_default_used <= 1'b1;
            end else begin
                o_bus_hz       <= bus;
                o_default_used <= 1'b0;
                if (r_job.path == PATH_PERF) begin
                    o_core_hz <= r_job.half ? prod[CORE_W:1] : prod[CORE_W-1:0];
                end else begin
                    o_core_hz <= {5'd0, r_job.tsc};
                end
            end
        end
    end
endmodule
